@@ rtl/core/lztd_pkg.sv @@
// lztd_pkg: shared types and constants of the lz77 token decoder
// holds the command item passed from the front part to the back part
// no dependencies

package lztd_pkg;

  localparam int LIT_W       = 8;
  localparam int OFF_W       = 12;
  localparam int LEN_W       = 4;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    CMD_LITERAL = 2'd0,
    CMD_COPY    = 2'd1,
    CMD_ERROR   = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e          kind;
    logic [LIT_W-1:0]   lit;
    logic [OFF_W-1:0]   off;
    logic [LEN_W-1:0]   len;
  } cmd_t;

endpackage

@@ rtl/core/lz77_token_decoder_core.sv @@
// lz77_token_decoder_core: top level of the lz77 token decoder
// depends on lztd_pkg, lztd_front, lztd_queue, lztd_back
//
// channel  dir  handshake               payload
// in       in   in_valid_i/in_stall_o   literal_byte_i match_offset_i match_length_i new_stream_i
// out      out  out_valid_o/out_stall_i out_byte_o last_of_token_o bad_token_o
//
// a copy item makes one history read per copied byte in the back part and then emits
// its literal byte; a literal or error item passes from idle through the literal or error state
// the front takes items while the two-entry command queue has room
// reset clears counters, queue and output valid; the window needs no clearing
// output stall holds the output register and the back sequencer, not the front

module lz77_token_decoder_core #(
  parameter int WINDOW_BYTES = 4096,
  parameter int LENGTH_MAX   = 15
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [lztd_pkg::LIT_W-1:0]  literal_byte_i,
  input  logic [lztd_pkg::OFF_W-1:0]  match_offset_i,
  input  logic [lztd_pkg::LEN_W-1:0]  match_length_i,
  input  logic                        new_stream_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [lztd_pkg::LIT_W-1:0]  out_byte_o,
  output logic                        last_of_token_o,
  output logic                        bad_token_o
);

  lztd_pkg::cmd_t  push_cmd, pop_cmd;
  logic            push, q_full, q_valid, pop;

  lztd_front #(
    .WINDOW_BYTES (WINDOW_BYTES),
    .LENGTH_MAX   (LENGTH_MAX)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .literal_byte_i (literal_byte_i),
    .match_offset_i (match_offset_i),
    .match_length_i (match_length_i),
    .new_stream_i   (new_stream_i),
    .q_full_i       (q_full),
    .push_o         (push),
    .cmd_o          (push_cmd)
  );

  lztd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .cmd_o   (pop_cmd)
  );

  lztd_back #(
    .WINDOW_BYTES (WINDOW_BYTES)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .cmd_i           (pop_cmd),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_byte_o      (out_byte_o),
    .last_of_token_o (last_of_token_o),
    .bad_token_o     (bad_token_o)
  );

endmodule

@@ rtl/core/lztd_front.sv @@
// lztd_front: accepts tokens, tracks the produced count and classifies each item
// depends on lztd_pkg

module lztd_front #(
  parameter int WINDOW_BYTES = 4096,
  parameter int LENGTH_MAX   = 15
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [lztd_pkg::LIT_W-1:0]  literal_byte_i,
  input  logic [lztd_pkg::OFF_W-1:0]  match_offset_i,
  input  logic [lztd_pkg::LEN_W-1:0]  match_length_i,
  input  logic                        new_stream_i,
  input  logic                        q_full_i,
  output logic                        push_o,
  output lztd_pkg::cmd_t              cmd_o
);

  localparam int PW   = $clog2(WINDOW_BYTES + 1);
  localparam int SUMW = PW + 1;
  localparam int CMPW = (PW > lztd_pkg::OFF_W) ? PW : lztd_pkg::OFF_W;

  logic [PW-1:0]                produced_q, produced_d;
  logic [PW-1:0]                base;
  logic [lztd_pkg::LEN_W-1:0]   len_c;
  logic [SUMW-1:0]              sum;
  logic                         is_err;

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    base  = new_stream_i ? '0 : produced_q;
    len_c = (32'(match_length_i) > LENGTH_MAX) ? lztd_pkg::LEN_W'(LENGTH_MAX)
                                                : match_length_i;
    is_err = (match_offset_i == '0 && len_c != '0) ||
             (CMPW'(match_offset_i) > CMPW'(base));
    sum = SUMW'(base) + SUMW'(len_c) + SUMW'(1);

    cmd_o.lit = literal_byte_i;
    cmd_o.off = match_offset_i;
    cmd_o.len = len_c;
    priority if (is_err) begin
      cmd_o.kind = lztd_pkg::CMD_ERROR;
    end else if (len_c == '0) begin
      cmd_o.kind = lztd_pkg::CMD_LITERAL;
    end else begin
      cmd_o.kind = lztd_pkg::CMD_COPY;
    end

    produced_d = produced_q;
    if (push_o) begin
      if (is_err) begin
        produced_d = base;
      end else if (sum > SUMW'(WINDOW_BYTES)) begin
        produced_d = PW'(WINDOW_BYTES);
      end else begin
        produced_d = sum[PW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      produced_q <= '0;
    end else begin
      produced_q <= produced_d;
    end
  end

endmodule

@@ rtl/core/lztd_queue.sv @@
// lztd_queue: short command queue between the front and back parts
// depends on lztd_pkg

module lztd_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  lztd_pkg::cmd_t  cmd_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output lztd_pkg::cmd_t  cmd_o
);

  localparam int D  = lztd_pkg::QUEUE_DEPTH;
  localparam int PW = (D > 1) ? $clog2(D) : 1;
  localparam int CW = $clog2(D + 1);

  lztd_pkg::cmd_t  mem_q [D];
  logic [PW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CW'(D));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(D - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(D - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

endmodule

@@ rtl/core/lztd_back.sv @@
// lztd_back: carries out commands, holds the history window and the output register
// depends on lztd_pkg

module lztd_back #(
  parameter int WINDOW_BYTES = 4096
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_valid_i,
  input  lztd_pkg::cmd_t              cmd_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [lztd_pkg::LIT_W-1:0]  out_byte_o,
  output logic                        last_of_token_o,
  output logic                        bad_token_o
);

  localparam int AW = $clog2(WINDOW_BYTES);
  localparam int CW = AW + 2;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_COPY = 2'd1;
  localparam logic [1:0] S_LIT  = 2'd2;
  localparam logic [1:0] S_ERR  = 2'd3;

  logic [1:0]                  state_q, state_d;
  logic [AW-1:0]               wp_q, wp_d, src_q, src_d;
  logic [lztd_pkg::LEN_W-1:0]  cnt_q, cnt_d;
  logic [lztd_pkg::LIT_W-1:0]  lit_q, lit_d;

  logic                        out_valid_q, out_valid_d;
  logic [lztd_pkg::LIT_W-1:0]  out_byte_q, out_byte_d;
  logic                        last_q, last_d, bad_q, bad_d;

  logic [lztd_pkg::LIT_W-1:0]  mem [WINDOW_BYTES];
  logic [lztd_pkg::LIT_W-1:0]  rd_q, byp_data_q, copy_byte;
  logic                        byp_q;
  logic                        we, re;
  logic [lztd_pkg::LIT_W-1:0]  wd;
  logic [AW-1:0]               ra, wp_inc, src_inc, src_first;
  logic [CW-1:0]               t;
  logic                        out_free;

  assign out_free        = !out_valid_q || !out_stall_i;
  assign copy_byte       = byp_q ? byp_data_q : rd_q;
  assign out_valid_o     = out_valid_q;
  assign out_byte_o      = out_byte_q;
  assign last_of_token_o = last_q;
  assign bad_token_o     = bad_q;

  always_comb begin
    wp_inc  = (wp_q == AW'(WINDOW_BYTES - 1)) ? '0 : wp_q + 1'b1;
    src_inc = (src_q == AW'(WINDOW_BYTES - 1)) ? '0 : src_q + 1'b1;
    t = CW'(wp_q) + CW'(WINDOW_BYTES) - CW'(cmd_i.off);
    src_first = (t >= CW'(WINDOW_BYTES)) ? AW'(t - CW'(WINDOW_BYTES)) : AW'(t);
  end

  always_comb begin
    state_d     = state_q;
    wp_d        = wp_q;
    src_d       = src_q;
    cnt_d       = cnt_q;
    lit_d       = lit_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_byte_d  = out_byte_q;
    last_d      = last_q;
    bad_d       = bad_q;
    pop_o       = 1'b0;
    we          = 1'b0;
    wd          = copy_byte;
    re          = 1'b0;
    ra          = src_inc;

    unique case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          pop_o = 1'b1;
          lit_d = cmd_i.lit;
          cnt_d = cmd_i.len;
          unique case (cmd_i.kind)
            lztd_pkg::CMD_COPY: begin
              re      = 1'b1;
              ra      = src_first;
              src_d   = src_first;
              state_d = S_COPY;
            end
            lztd_pkg::CMD_LITERAL: state_d = S_LIT;
            lztd_pkg::CMD_ERROR:   state_d = S_ERR;
            default:               state_d = S_IDLE;
          endcase
        end
      end
      S_COPY: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_byte_d  = copy_byte;
          last_d      = 1'b0;
          bad_d       = 1'b0;
          we          = 1'b1;
          wd          = copy_byte;
          wp_d        = wp_inc;
          cnt_d       = cnt_q - 1'b1;
          if (cnt_q == lztd_pkg::LEN_W'(1)) begin
            state_d = S_LIT;
          end else begin
            re    = 1'b1;
            ra    = src_inc;
            src_d = src_inc;
          end
        end
      end
      S_LIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_byte_d  = lit_q;
          last_d      = 1'b1;
          bad_d       = 1'b0;
          we          = 1'b1;
          wd          = lit_q;
          wp_d        = wp_inc;
          state_d     = S_IDLE;
        end
      end
      S_ERR: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_byte_d  = '0;
          last_d      = 1'b1;
          bad_d       = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    src_q      <= src_d;
    cnt_q      <= cnt_d;
    lit_q      <= lit_d;
    out_byte_q <= out_byte_d;
    last_q     <= last_d;
    bad_q      <= bad_d;
  end

  // history window, registered read with write-first bypass
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wp_q] <= wd;
    end
    if (re) begin
      rd_q <= mem[ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (re) begin
      byp_q      <= we && (wp_q == ra);
      byp_data_q <= wd;
    end
  end

endmodule
